// ===== rtl/morton_table_neighbor_search_macros.svh =====
// Assertion macros shared by the Morton table neighbour search RTL.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef MORTON_TABLE_NEIGHBOR_SEARCH_MACROS_SVH
`define MORTON_TABLE_NEIGHBOR_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define MTNS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);
// Condition in one cycle implies an expectation in the next.
`define MTNS_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |=> conseq) \
	else $error(msg);
`else
`define MTNS_ASSERT(label, prop, msg)
`define MTNS_ASSERT_NEXT(label, cond, conseq, msg)
`endif
`endif

// ===== rtl/mtns_pkg.sv =====
// Package for the Morton table neighbour search: sizes, codes, payload types.
// No dependencies; every other RTL file but the macros header uses it by scoped names.
package mtns_pkg;

	// Table and grid sizes.
	localparam int TABLE_DEPTH = 4096;
	localparam int AXIS_BITS   = 10;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = IDX_W + 1;
	localparam int CODE_W      = 3 * AXIS_BITS;
	localparam int LIMIT_W     = AXIS_BITS + 1;
	localparam int CFG_W       = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
	localparam int CFG_IDX_W   = 2;
	localparam int OP_W        = 2;
	localparam int DIR_W       = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAF_LAYER  = 2'd2;

	// Request operations.
	localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND     = 2'd1;
	localparam logic [OP_W-1:0] OP_NEIGHBOR = 2'd2;

	// Step directions: bits [2:1] select the axis, bit 0 set means a negative step.
	localparam logic [DIR_W-1:0] DIR_LAST = 3'd5;

	typedef enum logic [1:0] {
		ST_FOUND   = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_BLOCKED = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CMP,
		S_OWN_CHK,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  entry_index;
		logic [CODE_W-1:0] cell_code;
		logic              blocked_leaf;
		logic [DIR_W-1:0]  step_dir;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] found_index;
	} rsp_t;

	// One table entry as held in memory.
	typedef struct packed {
		logic              blocked;
		logic [CODE_W-1:0] code;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           entry;
	} ram_wr_t;

	// Result of stepping one cell from an entry's code.
	typedef struct packed {
		logic              outside;
		logic [CODE_W-1:0] target;
	} step_res_t;

	// Configuration as seen by the sequencer, already clamped.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               leaf;
	} cfg_view_t;

endpackage

// ===== rtl/morton_table_neighbor_search.sv =====
// Top level of the Morton table neighbour search: configuration registers and wiring.
// Depends on mtns_pkg, mtns_table_ram, mtns_cell_step and mtns_search_fsm.
//
// The block holds one octree layer as a table of 3-D Morton codes in ascending
// order, each with a blocked-leaf flag, and handles one request at a time; ready
// is low from acceptance until the response has been taken. Every request
// gives exactly one response. A write is answered in the cycle after it is
// accepted. A find is a binary search on the single read port of the table
// memory: each probe issues the midpoint address in S_FIND_RD and compares the
// read entry in S_FIND_CMP. A neighbour search reads its start entry, steps the
// cell and then walks the table one entry at a time, a read and a compare each,
// in the direction of the target code; that walk through the read port sets its
// length. Configuration is to be written only while idle; the block itself does
// not enforce it. entry_count above the table depth and axis_limit above the grid
// size are stored clamped.
module morton_table_neighbor_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  mtns_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output mtns_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [mtns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtns_pkg::CFG_W-1:0]      cfg_wdata
);

	logic [mtns_pkg::COUNT_W-1:0] count_q;
	logic [mtns_pkg::LIMIT_W-1:0] limit_q;
	logic                         leaf_q;
	logic [mtns_pkg::COUNT_W-1:0] count_wr;
	logic [mtns_pkg::LIMIT_W-1:0] limit_wr;

	mtns_pkg::cfg_view_t          cfg;
	mtns_pkg::ram_wr_t            ram_wr;
	logic [mtns_pkg::IDX_W-1:0]   ram_raddr;
	mtns_pkg::entry_t             ram_rdata;
	logic [mtns_pkg::DIR_W-1:0]   dir;
	mtns_pkg::step_res_t          step;

	// Written values at the register widths; clamped below to the table depth and grid size.
	assign count_wr = cfg_wdata[mtns_pkg::COUNT_W-1:0];
	assign limit_wr = cfg_wdata[mtns_pkg::LIMIT_W-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			limit_q <= mtns_pkg::LIMIT_W'(1 << mtns_pkg::AXIS_BITS);
			leaf_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtns_pkg::CFG_ENTRY_COUNT: begin
					if (count_wr > mtns_pkg::COUNT_W'(mtns_pkg::TABLE_DEPTH)) begin
						count_q <= mtns_pkg::COUNT_W'(mtns_pkg::TABLE_DEPTH);
					end else begin
						count_q <= count_wr;
					end
				end
				mtns_pkg::CFG_AXIS_LIMIT: begin
					if (limit_wr > mtns_pkg::LIMIT_W'(1 << mtns_pkg::AXIS_BITS)) begin
						limit_q <= mtns_pkg::LIMIT_W'(1 << mtns_pkg::AXIS_BITS);
					end else begin
						limit_q <= limit_wr;
					end
				end
				mtns_pkg::CFG_LEAF_LAYER: begin
					leaf_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.count = count_q;
	assign cfg.leaf  = leaf_q;

	// Table memory.
	mtns_table_ram u_ram (
		.clk      (clk),
		.wr       (ram_wr),
		.rd_addr  (ram_raddr),
		.rd_entry (ram_rdata)
	);

	// Cell step on the start entry as it comes out of the memory.
	mtns_cell_step u_step (
		.own  (ram_rdata.code),
		.dir  (dir),
		.lim  (limit_q),
		.step (step)
	);

	// Request sequencer.
	mtns_search_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg       (cfg),
		.ram_wr    (ram_wr),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.dir       (dir),
		.step      (step)
	);

endmodule

// ===== rtl/mtns_table_ram.sv =====
// Layer table memory: one write port, one read port with registered read data.
// Depends on mtns_pkg for the entry type and depth.
module mtns_table_ram (
	input  logic                         clk,
	input  mtns_pkg::ram_wr_t            wr,
	input  logic [mtns_pkg::IDX_W-1:0]   rd_addr,
	output mtns_pkg::entry_t             rd_entry
);

	mtns_pkg::entry_t mem_q [mtns_pkg::TABLE_DEPTH];
	mtns_pkg::entry_t rd_entry_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.entry;
		end
	end

	// Read port; data appears the cycle after the address.
	always_ff @(posedge clk) begin
		rd_entry_q <= mem_q[rd_addr];
	end

	assign rd_entry = rd_entry_q;

endmodule

// ===== rtl/mtns_cell_step.sv =====
// Cell step unit: de-interleaves a Morton code, steps one cell, checks the grid
// limit and re-interleaves the result. Depends on mtns_pkg.
module mtns_cell_step (
	input  logic [mtns_pkg::CODE_W-1:0]  own,
	input  logic [mtns_pkg::DIR_W-1:0]   dir,
	input  logic [mtns_pkg::LIMIT_W-1:0] lim,
	output mtns_pkg::step_res_t          step
);

	logic [mtns_pkg::AXIS_BITS-1:0] coord [3];
	logic [mtns_pkg::LIMIT_W-1:0]   moved [3];
	logic [2:0]                     bad;
	logic [1:0]                     axis;
	logic                           neg;

	assign axis = dir[2:1];
	assign neg  = dir[0];

	// Split the code into its three coordinates.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < mtns_pkg::AXIS_BITS; b++) begin
				coord[a][b] = own[3*b + a];
			end
		end
	end

	// Step the selected axis and check every coordinate against the limit.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			moved[a] = {1'b0, coord[a]};
			bad[a]   = 1'b0;
			if (2'(a) == axis) begin
				if (neg) begin
					bad[a]   = (coord[a] == '0);
					moved[a] = {1'b0, coord[a]} - mtns_pkg::LIMIT_W'(1);
				end else begin
					moved[a] = {1'b0, coord[a]} + mtns_pkg::LIMIT_W'(1);
				end
			end
			if (moved[a] >= lim) begin
				bad[a] = 1'b1;
			end
		end
	end

	// Interleave the stepped coordinates back into a code.
	always_comb begin
		step.outside = |bad;
		for (int b = 0; b < mtns_pkg::AXIS_BITS; b++) begin
			for (int a = 0; a < 3; a++) begin
				step.target[3*b + a] = moved[a][b];
			end
		end
	end

endmodule

// ===== rtl/mtns_search_fsm.sv =====
// Sequencer for writes, binary search and linear neighbour scan, with one shared
// code comparator on the memory read data. Depends on mtns_pkg and the macros header.
`include "morton_table_neighbor_search_macros.svh"

module mtns_search_fsm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  mtns_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output mtns_pkg::rsp_t                rsp,
	input  mtns_pkg::cfg_view_t           cfg,
	output mtns_pkg::ram_wr_t             ram_wr,
	output logic [mtns_pkg::IDX_W-1:0]    ram_raddr,
	input  mtns_pkg::entry_t              ram_rdata,
	output logic [mtns_pkg::DIR_W-1:0]    dir,
	input  mtns_pkg::step_res_t           step
);

	mtns_pkg::state_t state_q, state_d;

	logic [mtns_pkg::CODE_W-1:0]  key_q;
	logic [mtns_pkg::IDX_W-1:0]   idx_q;
	logic [mtns_pkg::DIR_W-1:0]   dir_q;
	logic [mtns_pkg::COUNT_W-1:0] lo_q;
	logic [mtns_pkg::COUNT_W-1:0] hiex_q;
	logic [mtns_pkg::IDX_W-1:0]   mid_q;
	logic                         down_q;
	mtns_pkg::status_t            status_q;
	logic [mtns_pkg::IDX_W-1:0]   index_q;

	mtns_pkg::status_t            fin_status;
	logic [mtns_pkg::IDX_W-1:0]   fin_index;
	logic [mtns_pkg::COUNT_W:0]   mid_sum;
	logic [mtns_pkg::IDX_W-1:0]   mid;
	logic [mtns_pkg::CODE_W-1:0]  cmp_key;
	logic                         rd_lt;
	logic                         rd_eq;
	logic                         rd_gt;
	logic                         walk_down;
	logic                         at_end;
	logic [mtns_pkg::COUNT_W-1:0] idx_inc;
	logic [mtns_pkg::COUNT_W-1:0] idx_ext;
	logic [mtns_pkg::IDX_W-1:0]   idx_next;
	logic [mtns_pkg::COUNT_W-1:0] start_ext;
	logic                         wr_in_range;
	logic                         passed;

	// Binary search midpoint over the half-open range [lo, hiex).
	assign mid_sum = {1'b0, lo_q} + {1'b0, hiex_q} - (mtns_pkg::COUNT_W + 1)'(1);
	assign mid     = mid_sum[mtns_pkg::IDX_W:1];

	// Shared comparator: read entry against the search key or the fresh step target.
	assign cmp_key = (state_q == mtns_pkg::S_OWN_CHK) ? step.target : key_q;
	assign rd_lt   = ram_rdata.code < cmp_key;
	assign rd_eq   = ram_rdata.code == cmp_key;
	assign rd_gt   = !rd_lt && !rd_eq;

	// Scan bookkeeping; on the first check the direction comes straight from the compare.
	assign walk_down = (state_q == mtns_pkg::S_OWN_CHK) ? rd_gt : down_q;
	assign idx_ext   = {1'b0, idx_q};
	assign idx_inc   = idx_ext + mtns_pkg::COUNT_W'(1);
	assign at_end    = walk_down ? (idx_q == '0) : (idx_inc == cfg.count);
	assign idx_next  = walk_down ? (idx_q - mtns_pkg::IDX_W'(1)) : (idx_q + mtns_pkg::IDX_W'(1));
	assign passed    = walk_down ? rd_lt : rd_gt;

	assign start_ext   = {1'b0, req.entry_index};
	assign wr_in_range = start_ext < mtns_pkg::COUNT_W'(mtns_pkg::TABLE_DEPTH);

	// Next state and the result to capture on entry to the response state.
	always_comb begin
		state_d    = state_q;
		fin_status = mtns_pkg::ST_MISSING;
		fin_index  = '0;
		unique case (state_q)
			mtns_pkg::S_IDLE: begin
				if (req_valid) begin
					priority if (req.op == mtns_pkg::OP_WRITE) begin
						state_d = mtns_pkg::S_DONE;
						if (wr_in_range) begin
							fin_status = mtns_pkg::ST_FOUND;
							fin_index  = req.entry_index;
						end
					end else if (req.op == mtns_pkg::OP_FIND) begin
						state_d = mtns_pkg::S_FIND_RD;
					end else if (req.op == mtns_pkg::OP_NEIGHBOR &&
							req.step_dir <= mtns_pkg::DIR_LAST &&
							start_ext < cfg.count) begin
						state_d = mtns_pkg::S_OWN_CHK;
					end else begin
						state_d = mtns_pkg::S_DONE;
					end
				end
			end
			mtns_pkg::S_FIND_RD: begin
				if (lo_q >= hiex_q) begin
					state_d = mtns_pkg::S_DONE;
				end else begin
					state_d = mtns_pkg::S_FIND_CMP;
				end
			end
			mtns_pkg::S_FIND_CMP: begin
				if (rd_eq) begin
					state_d    = mtns_pkg::S_DONE;
					fin_status = mtns_pkg::ST_FOUND;
					fin_index  = mid_q;
				end else begin
					state_d = mtns_pkg::S_FIND_RD;
				end
			end
			mtns_pkg::S_OWN_CHK: begin
				if (step.outside) begin
					state_d    = mtns_pkg::S_DONE;
					fin_status = mtns_pkg::ST_OUTSIDE;
				end else if (at_end) begin
					state_d = mtns_pkg::S_DONE;
				end else begin
					state_d = mtns_pkg::S_SCAN_RD;
				end
			end
			mtns_pkg::S_SCAN_RD: begin
				state_d = mtns_pkg::S_SCAN_CMP;
			end
			mtns_pkg::S_SCAN_CMP: begin
				if (rd_eq) begin
					state_d = mtns_pkg::S_DONE;
					if (cfg.leaf && ram_rdata.blocked) begin
						fin_status = mtns_pkg::ST_BLOCKED;
					end else begin
						fin_status = mtns_pkg::ST_FOUND;
						fin_index  = idx_q;
					end
				end else if (passed || at_end) begin
					state_d = mtns_pkg::S_DONE;
				end else begin
					state_d = mtns_pkg::S_SCAN_RD;
				end
			end
			mtns_pkg::S_DONE: begin
				if (rsp_ready) begin
					state_d = mtns_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mtns_pkg::S_IDLE;
			end
		endcase
	end

	// Handshake, memory address and write port.
	always_comb begin
		req_ready = (state_q == mtns_pkg::S_IDLE);
		rsp_valid = (state_q == mtns_pkg::S_DONE);
		unique case (state_q)
			mtns_pkg::S_FIND_RD: ram_raddr = mid;
			mtns_pkg::S_SCAN_RD: ram_raddr = idx_q;
			default:             ram_raddr = req.entry_index;
		endcase
		ram_wr.we    = (state_q == mtns_pkg::S_IDLE) && req_valid &&
			(req.op == mtns_pkg::OP_WRITE) && wr_in_range;
		ram_wr.addr  = req.entry_index;
		ram_wr.entry = '{blocked: req.blocked_leaf, code: req.cell_code};
	end

	assign dir             = dir_q;
	assign rsp.status      = status_q;
	assign rsp.found_index = index_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtns_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the search.
	always_ff @(posedge clk) begin
		if (state_q == mtns_pkg::S_IDLE && req_valid) begin
			key_q  <= req.cell_code;
			idx_q  <= req.entry_index;
			dir_q  <= req.step_dir;
			lo_q   <= '0;
			hiex_q <= cfg.count;
		end
		if (state_q == mtns_pkg::S_FIND_RD) begin
			mid_q <= mid;
		end
		if (state_q == mtns_pkg::S_FIND_CMP && !rd_eq) begin
			if (rd_lt) begin
				lo_q <= {1'b0, mid_q} + mtns_pkg::COUNT_W'(1);
			end else begin
				hiex_q <= {1'b0, mid_q};
			end
		end
		if (state_q == mtns_pkg::S_OWN_CHK) begin
			key_q  <= step.target;
			down_q <= rd_gt;
		end
		if (state_q == mtns_pkg::S_OWN_CHK || state_q == mtns_pkg::S_SCAN_CMP) begin
			idx_q <= idx_next;
		end
		if (state_d == mtns_pkg::S_DONE && state_q != mtns_pkg::S_DONE) begin
			status_q <= fin_status;
			index_q  <= fin_index;
		end
	end

	// A new request is never taken while a response is still waiting.
	`MTNS_ASSERT(a_ready_excl, req_ready |-> !rsp_valid, "request taken while a response waits")
	// The table is written only by an accepted write request.
	`MTNS_ASSERT(a_write_src, ram_wr.we |-> (req_valid && req_ready && req.op == mtns_pkg::OP_WRITE), "table written outside a write request")
	// Every response other than found carries index zero.
	`MTNS_ASSERT(a_miss_zero, (rsp_valid && rsp.status != mtns_pkg::ST_FOUND) |-> (rsp.found_index == '0), "non-zero index on a miss")
	// The scan never reads past the live part of the table.
	`MTNS_ASSERT(a_scan_range, (state_q == mtns_pkg::S_SCAN_RD) |-> (idx_ext < cfg.count), "scan index beyond entry count")
	// A table write is answered as found in the next cycle.
	`MTNS_ASSERT_NEXT(a_write_rsp, ram_wr.we, (rsp_valid && rsp.status == mtns_pkg::ST_FOUND), "write not acknowledged")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the Morton table neighbour search block.
// Needs mtns_pkg and the morton_table_neighbor_search RTL; requests are checked against
// a behavioural predictor of the layer table held inside this module or a given answer.
`timescale 1ns / 1ps

module testbench;
	import mtns_pkg::*;

	localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// One full set of layer registers.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [LIMIT_W-1:0] limit;
		logic               leaf;
	} setting_t;

	// One directed request, the registers it runs under and, where obvious, its answer.
	typedef struct packed {
		setting_t setting;
		req_t     request;
		bit       typed;
		rsp_t     answer;
	} directed_row_t;

	localparam setting_t CFG_AT_RESET  = {13'd0, 11'd1024, 1'b0};
	localparam setting_t CFG_LEAF_8    = {13'd8, 11'd1024, 1'b1};
	localparam setting_t CFG_NO_GRID   = {13'd8, 11'd0, 1'b0};
	localparam setting_t CFG_CLAMPED   = {13'd8, 11'd2047, 1'b0};
	localparam setting_t CFG_ONE_CELL  = {13'd8, 11'd1, 1'b1};
	localparam setting_t CFG_BIG_COUNT = {13'd8191, 11'd1024, 1'b0};

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	// Predictor copy of the layer table and its registers.
	logic [CODE_W-1:0] layer_code [TABLE_DEPTH];
	logic              layer_full [TABLE_DEPTH];
	setting_t          layer_cfg;

	rsp_t expected_rsp [$];
	int mismatches = 0;
	int unexpected = 0;
	bit calm = 1'b0;
	bit hold_off_pending = 1'b0;

	morton_table_neighbor_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// The run is cut short here if the block stops answering.
	initial begin
		#200_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Extracts one coordinate from a Morton code.
	function automatic int axis_coord(logic [CODE_W-1:0] code, int axis);
		logic [AXIS_BITS-1:0] v;
		for (int b = 0; b < AXIS_BITS; b++)
			v[b] = code[3 * b + axis];
		return int'(v);
	endfunction

	// Builds a Morton code from three coordinates, x in the lowest bit of each triple.
	function automatic logic [CODE_W-1:0] interleave(logic [2:0][AXIS_BITS-1:0] coords);
		logic [CODE_W-1:0] code;
		for (int b = 0; b < AXIS_BITS; b++)
			for (int a = 0; a < 3; a++)
				code[3 * b + a] = coords[a][b];
		return code;
	endfunction

	// Works out the response to one request and applies any table write.
	function automatic rsp_t predict_response(req_t rq);
		rsp_t res;
		int live, lo, hi, mid, lim, start, axis, v, i, inc, stop;
		logic [CODE_W-1:0] own, target;
		logic [2:0][AXIS_BITS-1:0] coords;
		res.status = ST_MISSING;
		res.found_index = '0;
		live = (layer_cfg.count > TABLE_DEPTH) ? TABLE_DEPTH : int'(layer_cfg.count);
		case (rq.op)
			OP_WRITE: begin
				layer_code[rq.entry_index] = rq.cell_code;
				layer_full[rq.entry_index] = rq.blocked_leaf;
				res.status = ST_FOUND;
				res.found_index = rq.entry_index;
			end
			OP_FIND: begin
				lo = 0;
				hi = live - 1;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (layer_code[mid] < rq.cell_code)
						lo = mid + 1;
					else if (layer_code[mid] == rq.cell_code) begin
						res.status = ST_FOUND;
						res.found_index = IDX_W'(mid);
						return res;
					end else
						hi = mid - 1;
				end
			end
			OP_NEIGHBOR: begin
				start = int'(rq.entry_index);
				if (rq.step_dir > DIR_LAST || start >= live)
					return res;
				lim = (layer_cfg.limit > (1 << AXIS_BITS)) ? (1 << AXIS_BITS)
					: int'(layer_cfg.limit);
				own = layer_code[start];
				axis = int'(rq.step_dir[2:1]);
				// Step one cell and keep every coordinate inside the grid.
				for (int a = 0; a < 3; a++) begin
					v = axis_coord(own, a);
					if (a == axis) begin
						if (rq.step_dir[0]) begin
							if (v == 0) begin
								res.status = ST_OUTSIDE;
								return res;
							end
							v = v - 1;
						end else
							v = v + 1;
					end
					if (v >= lim) begin
						res.status = ST_OUTSIDE;
						return res;
					end
					coords[a] = AXIS_BITS'(v);
				end
				target = interleave(coords);
				// Walk towards the target until it is met or passed.
				if (target < own) begin
					inc = -1;
					stop = -1;
				end else begin
					inc = 1;
					stop = live;
				end
				for (i = start + inc; i != stop; i += inc) begin
					if (layer_code[i] == target) begin
						if (layer_cfg.leaf && layer_full[i])
							res.status = ST_BLOCKED;
						else begin
							res.status = ST_FOUND;
							res.found_index = IDX_W'(i);
						end
						return res;
					end
					if ((inc < 0 && layer_code[i] < target) || (inc > 0 && layer_code[i] > target))
						return res;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_length();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic directed_row_t row(setting_t s, logic [OP_W-1:0] op,
			logic [IDX_W-1:0] idx, logic [CODE_W-1:0] code, logic blk,
			logic [DIR_W-1:0] dir, bit typed, status_t st, logic [IDX_W-1:0] fidx);
		directed_row_t d;
		d.setting = s;
		d.request = {op, idx, code, blk, dir};
		d.typed = typed;
		d.answer.status = st;
		d.answer.found_index = fidx;
		return d;
	endfunction

	// Random request against a table whose first live entries hold known codes.
	function automatic req_t next_request(int live);
		req_t rq;
		int r, k;
		rq.op = OP_UNUSED;
		rq.entry_index = IDX_W'($urandom);
		rq.cell_code = CODE_W'($urandom);
		rq.blocked_leaf = 1'($urandom);
		rq.step_dir = DIR_W'($urandom);
		k = (live > 0) ? $urandom_range(0, live - 1) : 0;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			rq.op = OP_NEIGHBOR;
			if (live > 0 && $urandom_range(0, 99) < 85)
				rq.entry_index = IDX_W'(k);
			if ($urandom_range(0, 99) < 90)
				rq.step_dir = DIR_W'($urandom_range(0, 5));
		end else if (r < 72) begin
			rq.op = OP_FIND;
			if (live > 0) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					rq.cell_code = layer_code[k];
				else if (r < 80)
					rq.cell_code = layer_code[k] + CODE_W'($urandom_range(0, 2)) - CODE_W'(1);
			end
		end else if (r < 92) begin
			rq.op = OP_WRITE;
			// Rewriting a live entry with its own code keeps the table sorted.
			if (live > 0 && $urandom_range(0, 99) < 70) begin
				rq.entry_index = IDX_W'(k);
				rq.cell_code = layer_code[k];
			end
		end
		return rq;
	endfunction

	// Offers one request after a random gap and records its expected response.
	task automatic send_request(req_t rq, bit typed, rsp_t typed_rsp);
		int gap;
		rsp_t predicted;
		gap = idle_length();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= rq;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_ready !== 1'b1)
			@(posedge clk);
		predicted = predict_response(rq);
		expected_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Writes all three registers on consecutive edges; only called while idle.
	task automatic configure(setting_t s);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ENTRY_COUNT;
		cfg_wdata <= CFG_W'(s.count);
		@(posedge clk);
		cfg_index <= CFG_AXIS_LIMIT;
		cfg_wdata <= CFG_W'(s.limit);
		@(posedge clk);
		cfg_index <= CFG_LEAF_LAYER;
		cfg_wdata <= CFG_W'(s.leaf);
		@(posedge clk);
		cfg_we <= 1'b0;
		layer_cfg = s;
	endtask

	// Response side: random stalls, a long hold-off on demand, and the checks.
	initial begin
		int stall;
		rsp_t want;
		stall = 0;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
				if (expected_rsp.size() == 0) begin
					unexpected++;
					if (mismatches + unexpected <= 10)
						$display("response with no request waiting: status %0d index %0d",
							rsp.status, rsp.found_index);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status || rsp.found_index !== want.found_index) begin
						mismatches++;
						if (mismatches + unexpected <= 10)
							$display("mismatch: status %0d index %0d, wanted status %0d index %0d",
								rsp.status, rsp.found_index, want.status, want.found_index);
					end
				end
			end
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				stall = 300;
			end else if (stall == 0 && $urandom_range(0, 99) < 30)
				stall = idle_length();
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else
				rsp_ready <= 1'b1;
		end
	end

	// Request side: reset, directed table, then random phases.
	initial begin
		directed_row_t rows [$];
		setting_t s;
		req_t rq;
		logic [CODE_W-1:0] code;
		int n, live, m, kind, sel, r, step;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		layer_cfg = CFG_AT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// A write to the spare register index must change nothing.
		cfg_we <= 1'b1;
		cfg_index <= CFG_UNUSED;
		cfg_wdata <= '1;
		@(posedge clk);
		cfg_we <= 1'b0;

		// Small sorted table: origin, its +x, +y, +z and (1,1,1) cells, then the far corner and two of its neighbours.
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'd0, 30'h0, 1'b0, 3'd0, 1, ST_FOUND, 12'd0));
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'd1, 30'h1, 1'b1, 3'd0, 1, ST_FOUND, 12'd1));
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'd2, 30'h2, 1'b0, 3'd0, 1, ST_FOUND, 12'd2));
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'd3, 30'h4, 1'b0, 3'd0, 1, ST_FOUND, 12'd3));
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'd4, 30'h7, 1'b1, 3'd0, 1, ST_FOUND, 12'd4));
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'd5, 30'h3FFFFFFB, 1'b0, 3'd0, 1,
			ST_FOUND, 12'd5));
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'd6, 30'h3FFFFFFE, 1'b0, 3'd0, 1,
			ST_FOUND, 12'd6));
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'd7, 30'h3FFFFFFF, 1'b0, 3'd0, 1,
			ST_FOUND, 12'd7));
		rows.push_back(row(CFG_AT_RESET, OP_WRITE, 12'hFFF, 30'h3FFFFFFF, 1'b1, 3'd7, 1,
			ST_FOUND, 12'hFFF));
		// Empty layer and the unused operation.
		rows.push_back(row(CFG_AT_RESET, OP_FIND, 12'd0, 30'h0, 1'b0, 3'd0, 1, ST_MISSING, 12'd0));
		rows.push_back(row(CFG_AT_RESET, OP_UNUSED, 12'hFFF, 30'h3FFFFFFF, 1'b1, 3'd7, 1,
			ST_MISSING, 12'd0));
		// Leaf layer of eight entries.
		rows.push_back(row(CFG_LEAF_8, OP_FIND, 12'd0, 30'h3FFFFFFF, 1'b0, 3'd0, 1,
			ST_FOUND, 12'd7));
		rows.push_back(row(CFG_LEAF_8, OP_FIND, 12'd0, 30'h3, 1'b0, 3'd0, 1, ST_MISSING, 12'd0));
		rows.push_back(row(CFG_LEAF_8, OP_NEIGHBOR, 12'd0, 30'h0, 1'b0, 3'd0, 0, ST_FOUND, 12'd0));
		rows.push_back(row(CFG_LEAF_8, OP_NEIGHBOR, 12'd0, 30'h0, 1'b0, 3'd1, 1,
			ST_OUTSIDE, 12'd0));
		rows.push_back(row(CFG_LEAF_8, OP_NEIGHBOR, 12'd0, 30'h0, 1'b0, 3'd2, 0, ST_FOUND, 12'd0));
		rows.push_back(row(CFG_LEAF_8, OP_NEIGHBOR, 12'd7, 30'h0, 1'b0, 3'd0, 1,
			ST_OUTSIDE, 12'd0));
		rows.push_back(row(CFG_LEAF_8, OP_NEIGHBOR, 12'd7, 30'h0, 1'b0, 3'd5, 0, ST_FOUND, 12'd0));
		rows.push_back(row(CFG_LEAF_8, OP_NEIGHBOR, 12'd4, 30'h0, 1'b0, 3'd3, 0, ST_FOUND, 12'd0));
		rows.push_back(row(CFG_LEAF_8, OP_NEIGHBOR, 12'd0, 30'h0, 1'b0, 3'd6, 1,
			ST_MISSING, 12'd0));
		rows.push_back(row(CFG_LEAF_8, OP_NEIGHBOR, 12'd8, 30'h0, 1'b0, 3'd0, 1,
			ST_MISSING, 12'd0));
		// Grid limits: none at all, clamped from above, and a single cell.
		rows.push_back(row(CFG_NO_GRID, OP_NEIGHBOR, 12'd2, 30'h0, 1'b0, 3'd0, 1,
			ST_OUTSIDE, 12'd0));
		rows.push_back(row(CFG_CLAMPED, OP_NEIGHBOR, 12'd6, 30'h0, 1'b0, 3'd0, 0,
			ST_FOUND, 12'd0));
		rows.push_back(row(CFG_ONE_CELL, OP_NEIGHBOR, 12'd0, 30'h0, 1'b0, 3'd2, 1,
			ST_OUTSIDE, 12'd0));
		// A count above the table depth still lets the last entry start a search.
		rows.push_back(row(CFG_BIG_COUNT, OP_NEIGHBOR, 12'hFFF, 30'h0, 1'b0, 3'd0, 1,
			ST_OUTSIDE, 12'd0));

		foreach (rows[k]) begin
			if (rows[k].setting != layer_cfg) begin
				wait_drained();
				configure(rows[k].setting);
			end
			send_request(rows[k].request, rows[k].typed, rows[k].answer);
		end

		// Random phases: fill a table, set the registers, then mixed requests.
		for (int phase = 0; phase < 21; phase++) begin
			calm = (phase == 5);
			kind = $urandom_range(0, 1);
			n = $urandom_range(1, 48);
			m = $urandom_range(30, 50);
			case (phase)
				3: begin
					kind = 2;
					n = $urandom_range(20, 40);
				end
				7: n = 0;
				default: ;
			endcase
			code = (kind == 1) ? CODE_W'($urandom_range(0, 30'h3FFFFF00) & ~63)
				: CODE_W'($urandom_range(0, 30'h3FFFFFFF - 240100));
			for (int i = 0; i < n; i++) begin
				rq.op = OP_WRITE;
				rq.entry_index = IDX_W'(i);
				rq.blocked_leaf = 1'($urandom);
				rq.step_dir = DIR_W'($urandom);
				r = $urandom_range(0, 99);
				if (kind == 1)
					step = (r < 90) ? 1 : 2;
				else
					step = (r < 70) ? 1 : (r < 90) ? $urandom_range(2, 8) : $urandom_range(9, 5000);
				if (kind == 2)
					code = CODE_W'($urandom);
				else if (i > 0)
					code = code + CODE_W'(step);
				rq.cell_code = code;
				send_request(rq, 1'b0, '0);
			end
			wait_drained();

			// Registers for this phase, grid limit often tied to a live entry.
			live = n;
			s.count = COUNT_W'(n);
			s.leaf = 1'($urandom);
			sel = $urandom_range(0, 9);
			case (sel)
				0: s.limit = 11'd0;
				1: s.limit = 11'd1;
				2: s.limit = 11'd2047;
				3, 4: s.limit = LIMIT_W'($urandom_range(1, 1024));
				5, 6, 7: begin
					if (live > 0)
						s.limit = LIMIT_W'(axis_coord(layer_code[$urandom_range(0, live - 1)],
							$urandom_range(0, 2)) + $urandom_range(0, 1));
					else
						s.limit = 11'd1024;
				end
				default: s.limit = 11'd1024;
			endcase
			configure(s);

			for (int j = 0; j < m; j++) begin
				// Receiver holds off while requests keep coming; later the sender drains.
				if (phase == 14 && j == 3)
					hold_off_pending = 1'b1;
				if (phase == 14 && j == 20)
					wait_drained();
				send_request(next_request(live), 1'b0, '0);
			end
			wait_drained();
		end
		calm = 1'b0;

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && unexpected == 0 && expected_rsp.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
